FILE: rtl/core/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants
// Item layouts, command, mode and event codes for the Manchester transceiver.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int          BufferBytesDef = 16;
	localparam logic [7:0]  SlotPeriodRst  = 8'd126;
	localparam int          SendLimit      = 248;
	localparam logic [7:0]  PtrStart       = 8'hfe;

	localparam logic [1:0]  CMD_SAMPLE = 2'd0;
	localparam logic [1:0]  CMD_WRITE  = 2'd1;
	localparam logic [1:0]  CMD_READ   = 2'd2;
	localparam logic [1:0]  CMD_SEND   = 2'd3;

	localparam logic [1:0]  MODE_IDLE = 2'd0;
	localparam logic [1:0]  MODE_RECV = 2'd1;
	localparam logic [1:0]  MODE_SEND = 2'd2;

	localparam logic [2:0]  EV_NONE  = 3'd0;
	localparam logic [2:0]  EV_RECV  = 3'd1;
	localparam logic [2:0]  EV_SENT  = 3'd2;
	localparam logic [2:0]  EV_RFAIL = 3'd3;
	localparam logic [2:0]  EV_SFAIL = 3'd4;

	typedef struct packed {
		logic [1:0] command;
		logic       pin_level;
		logic [3:0] byte_index;
		logic [7:0] byte_value;
		logic [7:0] send_bits;
	} in_item_t;

	typedef struct packed {
		logic       drive_low;
		logic [1:0] mode;
		logic       error_flag;
		logic [2:0] event_res;
		logic [7:0] event_bits;
		logic [7:0] read_byte;
		logic       bus_free;
	} out_item_t;

	typedef struct packed {
		logic       we;
		logic [4:0] addr;
		logic [7:0] data;
	} buf_wr_t;

endpackage

FILE: rtl/core/swm_if.sv
// ----------------------------------------------------------------------------
// swm_if: valid/ready channels
// Command channel and result channel of the transceiver.
// ----------------------------------------------------------------------------
interface swm_in_if;
	logic               valid;
	logic               ready;
	swm_pkg::in_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface swm_out_if;
	logic               valid;
	logic               ready;
	swm_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/swm_buf.sv
// ----------------------------------------------------------------------------
// swm_buf: frame buffer memory
// One write port, a host read port and a bit-pointer read port with bypass.
// ----------------------------------------------------------------------------
module swm_buf #(
	parameter int BUFFER_BYTES = swm_pkg::BufferBytesDef
) (
	input  logic                 clk,
	input  swm_pkg::buf_wr_t     wr,
	input  logic                 host_re,
	input  logic [3:0]           host_idx,
	output logic [7:0]           host_q,
	input  logic [4:0]           ptr_idx,
	output logic [7:0]           ptr_q
);
	localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

	logic [7:0]    mem [BUFFER_BYTES];
	logic [AW-1:0] waddr;
	logic [AW-1:0] haddr;
	logic [AW-1:0] paddr;

	assign waddr = AW'(wr.addr);
	assign haddr = AW'(host_idx);
	assign paddr = AW'(ptr_idx);

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[waddr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (host_re) begin
			host_q <= mem[haddr];
		end
	end

	// forward a same-cycle write to the pointer port
	always_ff @(posedge clk) begin
		if (wr.we && waddr == paddr) begin
			ptr_q <= wr.data;
		end else begin
			ptr_q <= mem[paddr];
		end
	end

endmodule

FILE: rtl/core/swm_ctrl.sv
// ----------------------------------------------------------------------------
// swm_ctrl: line state machine
// Slot timer, edge handling, receive and send sequencing over the buffer.
// ----------------------------------------------------------------------------
module swm_ctrl #(
	parameter int BUFFER_BYTES = swm_pkg::BufferBytesDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_data,
	input  logic                acc,
	input  swm_pkg::in_item_t   item,
	input  logic [7:0]          cur_byte,
	output swm_pkg::buf_wr_t    wr,
	output logic [4:0]          ptr_idx,
	output logic                rd_hit,
	output swm_pkg::out_item_t  res
);
	localparam int BufBits = BUFFER_BYTES * 8;
	localparam int SendLim = (BufBits < swm_pkg::SendLimit) ? BufBits : swm_pkg::SendLimit;

	logic [7:0] period_q, slot_q, bits_q, pos_q;
	logic [1:0] mode_q;
	logic       err_q, par_q, sh_q, fhl_q, prev_q, drive_q;

	logic [7:0] n_slot, n_bits, n_pos;
	logic [1:0] n_mode;
	logic       n_err, n_par, n_sh, n_fhl, n_prev, n_drive;
	logic [2:0] ev;
	logic       loaded, ok, s;
	logic [7:0] ptr;

	always_comb begin
		n_slot  = slot_q;
		n_bits  = bits_q;
		n_pos   = pos_q;
		n_mode  = mode_q;
		n_err   = err_q;
		n_par   = par_q;
		n_sh    = sh_q;
		n_fhl   = fhl_q;
		n_prev  = prev_q;
		n_drive = drive_q;
		ev      = swm_pkg::EV_NONE;
		loaded  = 1'b0;
		ok      = 1'b0;
		s       = 1'b0;
		wr      = '0;
		rd_hit  = 1'b0;
		if (acc) begin
			unique case (item.command)
				swm_pkg::CMD_SAMPLE: begin
					if (item.pin_level != prev_q) begin
						if (mode_q == swm_pkg::MODE_IDLE && !item.pin_level) begin
							n_mode = swm_pkg::MODE_RECV;
							n_err = 1'b0; n_par = 1'b0; n_sh = 1'b0; n_fhl = 1'b0;
							n_bits = swm_pkg::PtrStart;
							n_slot = period_q >> 1;
							loaded = 1'b1;
						end else if (mode_q == swm_pkg::MODE_SEND) begin
							// collision: someone else pulled a released line
							if (!item.pin_level && fhl_q) begin
								n_drive = 1'b0;
								n_mode = swm_pkg::MODE_IDLE;
								n_par = 1'b0; n_sh = 1'b0; n_fhl = 1'b0;
								n_err = 1'b1;
								ev = swm_pkg::EV_SFAIL;
							end
						end else if (mode_q == swm_pkg::MODE_RECV) begin
							n_slot = period_q >> 1;
							loaded = 1'b1;
						end
					end
					n_prev = item.pin_level;
					if (!loaded) begin
						if (slot_q >= period_q) begin
							n_slot = '0;
							if (n_mode == swm_pkg::MODE_RECV) begin
								if ({1'b0, n_bits} >= 9'(BufBits)) begin
									if (item.pin_level) begin
										n_mode = swm_pkg::MODE_IDLE;
										n_err = 1'b0; n_par = 1'b0; n_sh = 1'b0; n_fhl = 1'b0;
										ev = swm_pkg::EV_RFAIL;
									end else begin
										n_bits = n_bits + 8'd1;
									end
								end else if (!n_sh) begin
									n_fhl = item.pin_level;
									n_sh = 1'b1;
								end else if (item.pin_level == n_fhl) begin
									ok = item.pin_level ? n_par : !n_par;
									n_mode = swm_pkg::MODE_IDLE;
									n_err = 1'b0; n_par = 1'b0; n_sh = 1'b0; n_fhl = 1'b0;
									ev = ok ? swm_pkg::EV_RECV : swm_pkg::EV_RFAIL;
								end else begin
									wr.we = 1'b1;
									wr.addr = n_bits[7:3];
									wr.data = cur_byte;
									wr.data[n_bits[2:0]] = !item.pin_level;
									if (!item.pin_level) begin
										n_par = !n_par;
									end
									n_bits = n_bits + 8'd1;
									n_sh = 1'b0;
								end
							end else if (n_mode == swm_pkg::MODE_SEND) begin
								if (n_pos < n_bits) begin
									s = cur_byte[n_pos[2:0]];
									if (n_sh) begin
										n_drive = s; n_fhl = !s;
										n_pos = n_pos + 8'd1;
									end else begin
										n_drive = !s; n_fhl = s;
										if (s) begin
											n_par = !n_par;
										end
									end
									n_sh = !n_sh;
								end else if ({1'b0, n_bits} + 9'd2 == {1'b0, n_pos}) begin
									n_mode = swm_pkg::MODE_IDLE;
									n_err = 1'b0; n_par = 1'b0; n_sh = 1'b0;
									n_drive = 1'b0; n_fhl = 1'b1;
									ev = swm_pkg::EV_SENT;
								end else begin
									// preamble and parity slots
									n_drive = !n_par; n_fhl = n_par;
									n_pos = n_pos + 8'd1;
								end
							end
						end else begin
							n_slot = slot_q + 8'd1;
						end
					end
				end
				swm_pkg::CMD_WRITE: begin
					if (32'(item.byte_index) < BUFFER_BYTES) begin
						wr.we = 1'b1;
						wr.addr = {1'b0, item.byte_index};
						wr.data = item.byte_value;
					end
				end
				swm_pkg::CMD_READ: begin
					rd_hit = 32'(item.byte_index) < BUFFER_BYTES;
				end
				swm_pkg::CMD_SEND: begin
					if (mode_q == swm_pkg::MODE_IDLE && prev_q) begin
						n_mode = swm_pkg::MODE_SEND;
						n_err = 1'b0; n_par = 1'b0; n_sh = 1'b0; n_fhl = 1'b0;
						n_pos = swm_pkg::PtrStart;
						n_bits = (32'(item.send_bits) > SendLim) ? 8'(SendLim) : item.send_bits;
					end else begin
						n_err = 1'b1;
						ev = swm_pkg::EV_SFAIL;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// prefetch the byte under the next bit pointer
	assign ptr     = (n_mode == swm_pkg::MODE_SEND) ? n_pos : n_bits;
	assign ptr_idx = ptr[7:3];

	always_comb begin
		res            = '0;
		res.drive_low  = n_drive;
		res.mode       = n_mode;
		res.error_flag = n_err;
		res.event_res  = ev;
		res.event_bits = (ev != swm_pkg::EV_NONE) ? n_bits : 8'd0;
		res.bus_free   = (n_mode == swm_pkg::MODE_IDLE) && n_prev;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= swm_pkg::SlotPeriodRst;
		end else if (cfg_we) begin
			period_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			bits_q  <= '0;
			pos_q   <= '0;
			mode_q  <= swm_pkg::MODE_IDLE;
			err_q   <= 1'b0;
			par_q   <= 1'b0;
			sh_q    <= 1'b0;
			fhl_q   <= 1'b0;
			prev_q  <= 1'b1;
			drive_q <= 1'b0;
		end else begin
			slot_q  <= n_slot;
			bits_q  <= n_bits;
			pos_q   <= n_pos;
			mode_q  <= n_mode;
			err_q   <= n_err;
			par_q   <= n_par;
			sh_q    <= n_sh;
			fhl_q   <= n_fhl;
			prev_q  <= n_prev;
			drive_q <= n_drive;
		end
	end

endmodule

FILE: rtl/core/single_wire_manchester_bus_transceiver_core.sv
// ----------------------------------------------------------------------------
// single_wire_manchester_bus_transceiver_core: open-drain Manchester transceiver
// A result beat is registered and offered the cycle after its command is taken;
// one command beat per cycle while the sink is ready, else the single result
// register stalls commands. The buffer has registered reads; the byte under the
// bit pointer is prefetched each cycle so a slot tick can modify and write it
// back. Reset clears all control state; the buffer holds garbage until written.
// ----------------------------------------------------------------------------
module single_wire_manchester_bus_transceiver_core #(
	parameter int BUFFER_BYTES = swm_pkg::BufferBytesDef
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	swm_in_if.sink     cmd_ch,
	swm_out_if.source  res_ch
);
	logic               acc;
	logic               advance;
	swm_pkg::buf_wr_t   wr;
	logic [4:0]         ptr_idx;
	logic [7:0]         cur_byte;
	logic [7:0]         host_q;
	logic               rd_hit;
	swm_pkg::out_item_t res;

	logic               res_v_q;
	swm_pkg::out_item_t res_s1;
	logic               rd_hit_s1;

	// advance the result register when it is empty or being drained
	assign advance      = !res_v_q || res_ch.ready;
	assign cmd_ch.ready = advance;
	assign acc          = cmd_ch.valid && advance;

	swm_ctrl #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.acc      (acc),
		.item     (cmd_ch.data),
		.cur_byte (cur_byte),
		.wr       (wr),
		.ptr_idx  (ptr_idx),
		.rd_hit   (rd_hit),
		.res      (res)
	);

	// host reads land in host_q together with the result beat
	swm_buf #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_buf (
		.clk      (clk),
		.wr       (wr),
		.host_re  (acc),
		.host_idx (cmd_ch.data.byte_index),
		.host_q   (host_q),
		.ptr_idx  (ptr_idx),
		.ptr_q    (cur_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (advance) begin
			res_v_q <= cmd_ch.valid;
		end
	end

	// hold the payload while the sink stalls
	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1    <= res;
			rd_hit_s1 <= rd_hit;
		end
	end

	always_comb begin
		res_ch.data           = res_s1;
		res_ch.data.read_byte = rd_hit_s1 ? host_q : 8'd0;
	end
	assign res_ch.valid = res_v_q;

endmodule

FILE: dv/tb_single_wire_manchester_bus_transceiver_core.sv
// ----------------------------------------------------------------------------
// tb_single_wire_manchester_bus_transceiver_core: self-checking testbench
// Builds Manchester receive frames, looped-back send frames, buffer traffic
// and line noise at several slot periods. A line model in the bench predicts
// every result beat, and the monitor compares each beat field by field.
// ----------------------------------------------------------------------------
module tb_single_wire_manchester_bus_transceiver_core;
	import swm_pkg::*;

	localparam int NBytes = 16;
	localparam int NBits  = NBytes * 8;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_data;

	swm_in_if  cmd_ch ();
	swm_out_if res_ch ();

	single_wire_manchester_bus_transceiver_core #(.BUFFER_BYTES(NBytes)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd_ch   (cmd_ch),
		.res_ch   (res_ch)
	);

	// Beats waiting for the driver and the results the line model expects.
	in_item_t  pending_cmds[$];
	out_item_t expected_results[$];
	int        mismatches;
	int        stray_beats;
	int        issued;
	bit        calm;   // no idling on either side while set
	int        cmd_gap;
	int        res_stall;

	// Line model state.
	logic [7:0] m_period;
	logic [1:0] m_mode;
	logic       m_err;
	logic       m_par;
	logic       m_second;
	logic       m_first_lvl;
	logic [7:0] m_bits;
	logic [7:0] m_spos;
	logic [7:0] m_slot;
	logic       m_prev_pin;
	logic       m_drive;
	logic [7:0] m_buf [NBytes];

	always #6 clk = ~clk;

	function automatic void reset_flags();
		m_err = 1'b0;
		m_par = 1'b0;
		m_second = 1'b0;
		m_first_lvl = 1'b0;
	endfunction

	function automatic logic [2:0] rx_close(bit ok);
		m_mode = MODE_IDLE;
		reset_flags();
		return ok ? EV_RECV : EV_RFAIL;
	endfunction

	// One receive slot: preamble and overflow slots, then two halves per bit.
	function automatic logic [2:0] rx_slot(logic pin);
		logic [7:0] msk;
		if (int'(m_bits) >= NBits) begin
			if (pin)
				return rx_close(1'b0);
			m_bits = m_bits + 8'd1;
			return EV_NONE;
		end
		if (!m_second) begin
			m_first_lvl = pin;
			m_second = 1'b1;
			return EV_NONE;
		end
		msk = 8'd1 << m_bits[2:0];
		if (pin) begin
			if (m_first_lvl)
				return rx_close(m_par);
			m_buf[m_bits[6:3]] = m_buf[m_bits[6:3]] & ~msk;
		end else begin
			if (!m_first_lvl)
				return rx_close(!m_par);
			m_buf[m_bits[6:3]] = m_buf[m_bits[6:3]] | msk;
			m_par = ~m_par;
		end
		m_bits = m_bits + 8'd1;
		m_second = 1'b0;
		return EV_NONE;
	endfunction

	function automatic void set_drive(bit low);
		m_drive = low;
		m_first_lvl = !low;
	endfunction

	// One send slot: preamble, data halves, two parity slots, then done.
	function automatic logic [2:0] tx_slot();
		logic b;
		if (m_spos < m_bits) begin
			b = (m_spos[7:3] < NBytes) ? m_buf[m_spos[6:3]][m_spos[2:0]] : 1'b0;
			if (m_second) begin
				set_drive(b);
				m_spos = m_spos + 8'd1;
			end else begin
				set_drive(!b);
				if (b)
					m_par = ~m_par;
			end
			m_second = ~m_second;
		end else if (int'(m_bits) + 2 == int'(m_spos)) begin
			m_mode = MODE_IDLE;
			reset_flags();
			set_drive(1'b0);
			return EV_SENT;
		end else begin
			set_drive(!m_par);
			m_spos = m_spos + 8'd1;
		end
		return EV_NONE;
	endfunction

	function automatic out_item_t transceiver_next(in_item_t it);
		out_item_t r;
		logic [2:0] ev;
		logic [7:0] rd;
		bit reloaded;
		int n;
		ev = EV_NONE;
		rd = 8'd0;
		reloaded = 0;
		case (it.command)
			CMD_SAMPLE: begin
				if (it.pin_level != m_prev_pin) begin
					if (m_mode == MODE_IDLE && !it.pin_level) begin
						m_mode = MODE_RECV;
						reset_flags();
						m_bits = PtrStart;
						m_slot = m_period >> 1;
						reloaded = 1;
					end else if (m_mode == MODE_SEND) begin
						if (!it.pin_level && m_first_lvl) begin
							m_drive = 1'b0;
							m_mode = MODE_IDLE;
							reset_flags();
							m_err = 1'b1;
							ev = EV_SFAIL;
						end
					end else if (m_mode == MODE_RECV) begin
						m_slot = m_period >> 1;
						reloaded = 1;
					end
				end
				m_prev_pin = it.pin_level;
				if (!reloaded) begin
					if (m_slot >= m_period) begin
						m_slot = 8'd0;
						if (m_mode == MODE_RECV)
							ev = rx_slot(it.pin_level);
						else if (m_mode == MODE_SEND)
							ev = tx_slot();
					end else begin
						m_slot = m_slot + 8'd1;
					end
				end
			end
			CMD_WRITE: m_buf[it.byte_index] = it.byte_value;
			CMD_READ:  rd = m_buf[it.byte_index];
			default: begin
				if (m_mode == MODE_IDLE && m_prev_pin) begin
					n = it.send_bits;
					if (n > NBits)
						n = NBits;
					if (n > SendLimit)
						n = SendLimit;
					m_mode = MODE_SEND;
					reset_flags();
					m_spos = PtrStart;
					m_bits = n[7:0];
				end else begin
					m_err = 1'b1;
					ev = EV_SFAIL;
				end
			end
		endcase
		r.drive_low  = m_drive;
		r.mode       = m_mode;
		r.error_flag = m_err;
		r.event_res  = ev;
		r.event_bits = (ev != EV_NONE) ? m_bits : 8'd0;
		r.read_byte  = rd;
		r.bus_free   = (m_mode == MODE_IDLE) && m_prev_pin;
		return r;
	endfunction

	// Queue a beat and its predicted result.
	task automatic issue(logic [1:0] c, logic p, logic [3:0] idx, logic [7:0] v,
			logic [7:0] nb);
		in_item_t it;
		it.command = c;
		it.pin_level = p;
		it.byte_index = idx;
		it.byte_value = v;
		it.send_bits = nb;
		issued++;
		pending_cmds.push_back(it);
		expected_results.push_back(transceiver_next(it));
	endtask

	task automatic sample(logic p);
		issue(CMD_SAMPLE, p, 4'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic read_any();
		issue(CMD_READ, 1'($urandom), 4'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Hold a level for one slot, now and then slipping in a buffer read.
	task automatic hold_slot(logic p);
		for (int i = 0; i <= int'(m_period); i++) begin
			if ($urandom_range(0, 40) == 0)
				read_any();
			sample(p);
		end
	endtask

	// Drive a receive frame onto the line; optionally break the parity or
	// issue a send mid-frame, while the line is busy, and another after it.
	task automatic rx_frame(int nbits, bit bad_par, bit busy_send);
		bit b;
		bit par;
		par = 0;
		repeat ($urandom_range(1, 3))
			sample(1'b1);
		hold_slot(1'b0);
		hold_slot(1'b0);
		for (int i = 0; i < nbits; i++) begin
			b = $urandom_range(0, 1);
			par ^= b;
			if (busy_send && i == nbits / 2)
				issue(CMD_SEND, 1'b0, 4'd0, 8'd0, 8'($urandom));
			hold_slot(b);
			hold_slot(!b);
		end
		hold_slot(par ^ bad_par);
		hold_slot(par ^ bad_par);
		if (busy_send)
			issue(CMD_SEND, 1'b1, 4'd0, 8'd0, 8'($urandom_range(0, 16)));
		repeat ($urandom_range(1, 3))
			sample(1'b1);
	endtask

	// Start a send and loop the line back; optionally pull the line low
	// against the released driver to force a collision.
	task automatic tx_frame(logic [7:0] nb, bit collide);
		int guard;
		int hit;
		guard = 270 * (int'(m_period) + 1);
		hit = $urandom_range(0, 60 * (int'(m_period) + 1));
		sample(1'b1);
		issue(CMD_SEND, 1'b0, 4'($urandom), 8'($urandom), nb);
		for (int i = 0; i < guard && m_mode == MODE_SEND; i++) begin
			if (collide && i >= hit && !m_drive)
				sample(1'b0);
			else
				sample(!m_drive);
			if (i == 3 && $urandom_range(0, 3) == 0)
				issue(CMD_SEND, 1'b0, 4'd0, 8'd0, 8'($urandom));
		end
		repeat (2)
			sample(1'b1);
	endtask

	function automatic int pick_bits();
		return $urandom_range(0, 12);
	endfunction

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || cmd_ch.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic set_period(logic [7:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_period = v;
	endtask

	// Command driver: draw a gap per beat, hold valid until taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (cmd_gap != 0) begin
					cmd_ch.valid <= 1'b0;
					cmd_gap <= cmd_gap - 1;
				end else if (pending_cmds.size() != 0) begin
					cmd_ch.data <= pending_cmds.pop_front();
					cmd_ch.valid <= 1'b1;
					cmd_gap <= calm ? 0 : $urandom_range(0, 4);
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each beat with the oldest prediction, and
	// stall ready for a drawn number of cycles after each beat.
	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		int n;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got = res_ch.data;
				if (expected_results.size() == 0) begin
					stray_beats++;
					$display("unexpected result beat %h", got);
				end else begin
					want = expected_results.pop_front();
					if (got.drive_low !== want.drive_low || got.mode !== want.mode
							|| got.error_flag !== want.error_flag
							|| got.event_res !== want.event_res
							|| got.event_bits !== want.event_bits
							|| got.read_byte !== want.read_byte
							|| got.bus_free !== want.bus_free) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("mismatch: exp drv %b mode %0d err %b ev %0d bits %0d",
								want.drive_low, want.mode, want.error_flag,
								want.event_res, want.event_bits);
							$write(" rd %h free %b;", want.read_byte, want.bus_free);
							$write(" got drv %b mode %0d err %b ev %0d bits %0d",
								got.drive_low, got.mode, got.error_flag,
								got.event_res, got.event_bits);
							$display(" rd %h free %b", got.read_byte, got.bus_free);
						end
					end
				end
				n = calm ? 0 : $urandom_range(0, 4);
				res_stall <= n;
				res_ch.ready <= (n == 0);
			end else if (res_stall != 0) begin
				res_stall <= res_stall - 1;
				res_ch.ready <= (res_stall == 1);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [7:0] periods [6];
		int r;
		int stop;
		periods = '{8'd2, 8'd255, 8'd3, 8'd2, 8'd4, 8'd2};
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 8'd0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		res_ch.ready = 1'b0;
		calm = 0;
		cmd_gap = 0;
		res_stall = 0;
		mismatches = 0;
		stray_beats = 0;
		issued = 0;
		m_period = SlotPeriodRst;
		m_mode = MODE_IDLE;
		reset_flags();
		m_bits = 8'd0;
		m_spos = 8'd0;
		m_slot = 8'd0;
		m_prev_pin = 1'b1;
		m_drive = 1'b0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;

		// Directed: fill the buffer with extreme bytes, read both ends, then
		// open a receive at the reset slot period and run into its first
		// preamble slot.
		for (int i = 0; i < NBytes; i++)
			issue(CMD_WRITE, 1'b0, i[3:0], (i % 2) ? 8'hff : 8'h00, 8'd0);
		issue(CMD_READ, 1'b0, 4'd0, 8'd0, 8'd0);
		issue(CMD_READ, 1'b1, 4'd15, 8'd0, 8'd0);
		repeat (3)
			sample(1'b1);
		repeat (100)
			sample(1'b0);

		// Short slots for the directed frames; a high preamble slot aborts the receive.
		set_period(8'd2);
		repeat (12)
			sample(1'b1);
		rx_frame(1, 0, 1);
		tx_frame(8'd1, 0);
		tx_frame(8'd0, 0);
		tx_frame(8'd255, 1);
		rx_frame(0, 0, 0);
		rx_frame(0, 1, 0);

		// Random phases at several slot periods.
		foreach (periods[p]) begin
			set_period(periods[p]);
			calm = ($urandom_range(0, 3) == 0);
			stop = issued + 100;
			if (periods[p] > 8'd100) begin
				issue(CMD_WRITE, 1'b0, 4'($urandom), 8'($urandom), 8'($urandom));
				read_any();
				repeat (6)
					sample(1'b1);
			end else begin
				while (issued < stop) begin
					r = $urandom_range(0, 9);
					if (r <= 3)
						rx_frame(pick_bits(), $urandom_range(0, 5) == 0,
							$urandom_range(0, 6) == 0);
					else if (r <= 6) begin
						if ($urandom_range(0, 7) == 0)
							tx_frame(8'($urandom_range(100, 255)), 1);
						else
							tx_frame(8'($urandom_range(0, 24)), $urandom_range(0, 4) == 0);
					end else if (r == 7)
						repeat ($urandom_range(1, 4)) begin
							issue(CMD_WRITE, 1'b0, 4'($urandom), 8'($urandom), 8'($urandom));
							read_any();
						end
					else
						repeat ($urandom_range(1, 8))
							sample(1'($urandom));
					if (m_mode == MODE_RECV)
						repeat (4 * (int'(m_period) + 1))
							sample(1'b1);
				end
			end
		end

		wait_drained();
		repeat (10)
			@(posedge clk);
		if (mismatches == 0 && stray_beats == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/swm_pkg.sv
rtl/core/swm_if.sv
rtl/core/swm_buf.sv
rtl/core/swm_ctrl.sv
rtl/core/single_wire_manchester_bus_transceiver_core.sv
dv/tb_single_wire_manchester_bus_transceiver_core.sv
